>>> design/nearest_track_associator_macros.svh
// Assertion macros used by the nearest track associator top level.
`ifndef NEAREST_TRACK_ASSOCIATOR_MACROS_SVH
`define NEAREST_TRACK_ASSOCIATOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define NTA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest_track_associator: assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define NTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest_track_associator: assertion failed");
`else
`define NTA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define NTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/nta_pkg.sv
// Package with the constants, register codes and types of the nearest track associator.
package nta_pkg;

    localparam int MAX_TRACKS = 32;
    localparam int IDX_W      = $clog2(MAX_TRACKS);
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

    localparam int POS_W      = 24;
    localparam int STAMP_W    = 32;
    localparam int MAG_W      = 24;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int DIST_W     = 50;
    localparam int GATE_W     = 50;
    localparam int GAP_W      = 32;
    localparam int LABEL_W    = 5;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 50;

    localparam logic [CFG_IDX_W-1:0] REG_GATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP  = 1'b1;

    localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(49000000);
    localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(5000);

    // One stored track, also used for the captured detection.
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [STAMP_W-1:0]      stamp;
    } t_track;

    // Scored candidate leaving the distance pipeline.
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_sq;
        logic              gap_ok;
    } t_score;

endpackage

>>> design/nta_det_if.sv
// Channel interface carrying one detection per transaction.
interface nta_det_if import nta_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [STAMP_W-1:0]      stamp_ms;

    modport source (output valid, pos_x, pos_y, pos_z, stamp_ms, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, stamp_ms, output ready);
endinterface

>>> design/nta_res_if.sv
// Channel interface carrying one association result per transaction.
interface nta_res_if import nta_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] track_label;
    logic               new_track;
    logic               table_full;

    modport source (output valid, track_label, new_track, table_full, input ready);
    modport sink   (input valid, track_label, new_track, table_full, output ready);
endinterface

>>> design/nta_track_ram.sv
// Track memory: one write port and one read port with registered read data.
module nta_track_ram import nta_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_track           i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_track           o_rdata
);

    t_track r_mem [MAX_TRACKS];
    t_track r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/nta_score.sv
// Three-stage pipeline that scores one stored track against the detection.
module nta_score import nta_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_v,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  t_track           i_track,
    input  t_track           i_det,
    input  logic [GAP_W-1:0] i_max_gap,
    output t_score           o_score,
    output logic             o_busy
);

    logic signed [POS_W:0]   dx, dy, dz;
    logic [MAG_W-1:0]        mx, my, mz;
    logic signed [STAMP_W:0] gap;
    logic                    gap_ok;

    logic                    r_s1_v, r_s2_v, r_s3_v;
    logic [IDX_W-1:0]        r_s1_idx, r_s2_idx, r_s3_idx;
    logic                    r_s1_gap, r_s2_gap, r_s3_gap;
    logic [MAG_W-1:0]        r_mx, r_my, r_mz;
    logic [SQ_W-1:0]         r_sqx, r_sqy, r_sqz;
    logic [DIST_W-1:0]       r_dist;

    // Differences are formed one bit wider so that they never wrap.
    assign dx = $signed({i_track.x[POS_W-1], i_track.x}) - $signed({i_det.x[POS_W-1], i_det.x});
    assign dy = $signed({i_track.y[POS_W-1], i_track.y}) - $signed({i_det.y[POS_W-1], i_det.y});
    assign dz = $signed({i_track.z[POS_W-1], i_track.z}) - $signed({i_det.z[POS_W-1], i_det.z});
    assign mx = dx[POS_W] ? MAG_W'(-dx) : MAG_W'(dx);
    assign my = dy[POS_W] ? MAG_W'(-dy) : MAG_W'(dy);
    assign mz = dz[POS_W] ? MAG_W'(-dz) : MAG_W'(dz);

    // Signed gap, exact: an older detection gives a negative gap and passes.
    assign gap    = $signed({1'b0, i_det.stamp}) - $signed({1'b0, i_track.stamp});
    assign gap_ok = gap < $signed({1'b0, i_max_gap});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= i_rd_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_rd_idx;
        r_s1_gap <= gap_ok;
        r_mx     <= mx;
        r_my     <= my;
        r_mz     <= mz;

        r_s2_idx <= r_s1_idx;
        r_s2_gap <= r_s1_gap;
        r_sqx    <= r_mx * r_mx;
        r_sqy    <= r_my * r_my;
        r_sqz    <= r_mz * r_mz;

        r_s3_idx <= r_s2_idx;
        r_s3_gap <= r_s2_gap;
        r_dist   <= DIST_W'(r_sqx) + DIST_W'(r_sqy) + DIST_W'(r_sqz);
    end

    assign o_score.valid   = r_s3_v;
    assign o_score.idx     = r_s3_idx;
    assign o_score.dist_sq = r_dist;
    assign o_score.gap_ok  = r_s3_gap;

    // High while any stage still holds a track that has not been scored.
    assign o_busy = r_s1_v || r_s2_v || r_s3_v;

endmodule

>>> design/nearest_track_associator.sv
// Top level of the gated nearest-neighbor track associator.
// One detection is taken per transaction on i_det, and one result leaves per
// transaction on o_res. On an empty table the scan issues no memory read. The
// next detection is accepted in the cycle after the result is loaded into the
// output register. The track memory is read one entry per cycle into a
// three-stage distance pipeline; the scan waits for the last compare to settle
// and the decision state waits until the output register is free.
// Configuration writes go through i_cfg_we, i_cfg_idx and i_cfg_data: index 0
// is the squared distance gate and index 1 the time gap limit, and they should
// be written only while the block is idle.
// A detection matches the nearest stored track whose squared distance is below
// the gate and whose signed time gap is below the limit; the first of equal
// distances wins. A match overwrites that track, no match appends a track, and
// with a full table the detection is dropped and reported with table_full set
// and a label of zero. Track contents need no clearing after reset, because
// only entries below the track count are ever read.
module nearest_track_associator import nta_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    nta_det_if.sink               i_det,
    nta_res_if.source             o_res
);

`include "nearest_track_associator_macros.svh"

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [GATE_W-1:0]  r_gate;
    logic [GAP_W-1:0]   r_gap;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_issue;
    logic               r_rd_v;
    logic [IDX_W-1:0]   r_rd_idx;
    t_track             r_det;

    logic               r_found;
    logic [IDX_W-1:0]   r_best;
    logic [DIST_W-1:0]  r_best_d;

    logic               r_out_v;
    logic [LABEL_W-1:0] r_out_label;
    logic               r_out_new;
    logic               r_out_full;

    logic               det_acc;
    logic               issue;
    logic               busy;
    logic               out_free;
    logic               decide_go;
    logic               is_full;
    logic               cand;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_track             rd_track;
    t_score             score;
    logic               score_busy;

    assign i_det.ready = (r_state == ST_IDLE);
    assign det_acc     = i_det.valid && i_det.ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= GATE_RESET;
            r_gap  <= GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GATE: r_gate <= i_cfg_data[GATE_W-1:0];
                REG_GAP:  r_gap  <= i_cfg_data[GAP_W-1:0];
                default:  ;
            endcase
        end
    end

    // The scan issues one memory read per cycle until all stored tracks are out,
    // and stays busy until the last of them has left the distance pipeline.
    assign issue = (r_state == ST_SCAN) && (r_issue < r_count);
    assign busy  = issue || r_rd_v || score_busy || r_issue != r_count;

    nta_track_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_det),
        .i_re    (issue),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (rd_track)
    );

    nta_score u_score (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_v    (r_rd_v),
        .i_rd_idx  (r_rd_idx),
        .i_track   (rd_track),
        .i_det     (r_det),
        .i_max_gap (r_gap),
        .o_score   (score),
        .o_busy    (score_busy)
    );

    // A scored track replaces the best so far only when strictly nearer, so the
    // first of several equal distances is kept.
    assign cand = score.valid && score.gap_ok && (score.dist_sq < r_gate) &&
                  (!r_found || (score.dist_sq < r_best_d));

    assign out_free  = !r_out_v || o_res.ready;
    assign decide_go = (r_state == ST_DECIDE) && out_free;
    assign is_full   = (r_count >= CNT_W'(MAX_TRACKS));
    assign ram_we    = decide_go && (r_found || !is_full);
    assign ram_waddr = r_found ? r_best : r_count[IDX_W-1:0];

    // The memory is written only in the decision cycle, after every read of
    // the scan has left the pipeline, so reads and writes never overlap.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (det_acc) n_state = ST_SCAN;
            ST_SCAN:   if (!busy && !r_rd_v && !score.valid) n_state = ST_DECIDE;
            ST_DECIDE: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_issue <= '0;
            r_rd_v  <= 1'b0;
            r_found <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= issue;
            if (det_acc) begin
                r_issue <= '0;
                r_found <= 1'b0;
            end else begin
                if (issue) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (cand) begin
                    r_found <= 1'b1;
                end
            end
            if (decide_go && !r_found && !is_full) begin
                r_count <= r_count + 1'b1;
            end
            if (decide_go) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (det_acc) begin
            r_det.x     <= i_det.pos_x;
            r_det.y     <= i_det.pos_y;
            r_det.z     <= i_det.pos_z;
            r_det.stamp <= i_det.stamp_ms;
        end
        r_rd_idx <= r_issue[IDX_W-1:0];
        if (cand) begin
            r_best   <= score.idx;
            r_best_d <= score.dist_sq;
        end
        if (decide_go) begin
            if (r_found) begin
                r_out_label <= LABEL_W'(r_best);
                r_out_new   <= 1'b0;
                r_out_full  <= 1'b0;
            end else if (is_full) begin
                r_out_label <= '0;
                r_out_new   <= 1'b0;
                r_out_full  <= 1'b1;
            end else begin
                r_out_label <= LABEL_W'(r_count[IDX_W-1:0]);
                r_out_new   <= 1'b1;
                r_out_full  <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.track_label = r_out_label;
    assign o_res.new_track   = r_out_new;
    assign o_res.table_full  = r_out_full;

    `NTA_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_TRACKS))
    `NTA_ASSERT_SAME(a_read_in_range, i_clk, i_rst_n, issue, r_issue < r_count)
    `NTA_ASSERT_SAME(a_write_idle_pipe, i_clk, i_rst_n, ram_we,
        !issue && !r_rd_v && !score_busy)
    `NTA_ASSERT_SAME(a_drop_result, i_clk, i_rst_n, o_res.valid && o_res.table_full,
        !o_res.new_track && o_res.track_label == '0)
    `NTA_ASSERT_NEXT(a_append_counts, i_clk, i_rst_n, decide_go && !r_found && !is_full,
        r_count == $past(r_count) + 1'b1)

endmodule
